>>> hw/rtl/sgbt_pkg.sv
// ----------------------------------------------------------------------------
// sgbt_pkg
// Shared types and constants of the spherical grid bilinear taper core.
// ----------------------------------------------------------------------------
package sgbt_pkg;

    // Default number of longitude points of the height grid.
    localparam int LON_POINTS_DEF = 512;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int RAD_W  = 31;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_LAYER = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_UPPER = 2'd2;

    // Request codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Number of quotient bits produced by the divider pipeline.
    localparam int QUO_W = 32;

    // One input item.
    typedef struct packed {
        logic               req_type;
        logic [8:0]         lat_row;
        logic [8:0]         lon_col;
        logic signed [23:0] height_value;
        logic [31:0]        colatitude;
        logic [31:0]        longitude;
        logic [30:0]        point_radius;
        logic [30:0]        element_radius;
    } t_req;

    // One result item.
    typedef struct packed {
        logic signed [31:0] delta_radius;
        logic               in_scope;
    } t_res;

    // Configuration registers.
    typedef struct packed {
        logic [RAD_W-1:0] layer;
        logic [RAD_W-1:0] lower;
        logic [RAD_W-1:0] upper;
    } t_cfg;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic               is_query;
        logic               in_scope;
        logic               below;
        logic [8:0]         lat_row;
        logic [8:0]         lon_col;
        logic signed [23:0] height;
        logic [31:0]        theta;
        logic [31:0]        phi;
        logic [30:0]        point_radius;
    } t_cmd;

    // Control flags carried alongside the divider pipeline.
    typedef struct packed {
        logic is_query;
        logic in_scope;
        logic den_zero;
        logic neg;
        logic ovf;
    } t_tag;

endpackage

>>> hw/rtl/sgbt_front.sv
// ----------------------------------------------------------------------------
// sgbt_front
// Accepts items, drops out-of-range writes, clamps angles and classifies
// queries by radial scope and side of the layer.
// ----------------------------------------------------------------------------
module sgbt_front #(
    parameter int LON_POINTS = sgbt_pkg::LON_POINTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sgbt_pkg::t_req   i_req,
    input  sgbt_pkg::t_cfg   i_cfg,
    input  logic             i_q_full,
    output logic             o_busy,
    output logic             o_push,
    output sgbt_pkg::t_cmd   o_cmd
);

    localparam int LAT = LON_POINTS / 2 + 1;

    logic           r_valid;
    sgbt_pkg::t_cmd r_cmd;
    sgbt_pkg::t_cmd n_cmd;
    logic           hold;
    logic           accept;
    logic           write_ok;
    logic           keep;

    // The stage holds its item while the queue is full.
    assign hold   = r_valid && i_q_full;
    assign accept = i_start && !hold;
    assign o_busy = hold;
    assign o_push = r_valid && !i_q_full;
    assign o_cmd  = r_cmd;

    // Classify the incoming item.
    always_comb begin
        n_cmd.is_query     = (i_req.req_type == sgbt_pkg::REQ_QUERY);
        n_cmd.lat_row      = i_req.lat_row;
        n_cmd.lon_col      = i_req.lon_col;
        n_cmd.height       = i_req.height_value;
        n_cmd.point_radius = i_req.point_radius;
        n_cmd.in_scope     = !(i_req.element_radius > i_cfg.upper) &&
                             !(i_req.element_radius < i_cfg.lower);
        n_cmd.below        = (i_req.element_radius < i_cfg.layer);
        // Keep the angles away from the poles and from the seam.
        if (i_req.colatitude == 32'd0) begin
            n_cmd.theta = 32'd1;
        end else if (i_req.colatitude[31]) begin
            n_cmd.theta = 32'h7FFF_FFFF;
        end else begin
            n_cmd.theta = i_req.colatitude;
        end
        n_cmd.phi = (i_req.longitude == 32'd0) ? 32'd1 : i_req.longitude;
        write_ok  = (32'(i_req.lat_row) < 32'(LAT)) &&
                    (32'(i_req.lon_col) < 32'(LON_POINTS));
        keep      = n_cmd.is_query || write_ok;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!hold) begin
            r_valid <= accept && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> hw/rtl/sgbt_queue.sv
// ----------------------------------------------------------------------------
// sgbt_queue
// Two-entry queue between the front end and the back end. The back end
// takes the head whenever the queue holds an entry.
// ----------------------------------------------------------------------------
module sgbt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sgbt_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output sgbt_pkg::t_cmd o_cmd
);

    sgbt_pkg::t_cmd r_ent [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           pop;

    assign pop     = (r_cnt != 2'd0);
    assign o_valid = pop;
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_ent[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/sgbt_div.sv
// ----------------------------------------------------------------------------
// sgbt_div
// Pipelined restoring divider, one quotient bit per stage. The caller must
// hand in the upper remainder reduced below the divisor; the divider itself does not enforce this.
// ----------------------------------------------------------------------------
module sgbt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  sgbt_pkg::t_tag              i_tag,
    input  logic [30:0]                 i_rem,
    input  logic [31:0]                 i_lo,
    input  logic [30:0]                 i_div,
    output logic                        o_valid,
    output sgbt_pkg::t_tag              o_tag,
    output logic [sgbt_pkg::QUO_W-1:0]  o_quo
);

    localparam int STEPS = sgbt_pkg::QUO_W;

    logic                 r_v   [STEPS+1];
    sgbt_pkg::t_tag       r_tag [STEPS+1];
    logic [30:0]          r_rem [STEPS+1];
    logic [31:0]          r_lo  [STEPS+1];
    logic [30:0]          r_div [STEPS+1];
    logic [STEPS-1:0]     r_quo [STEPS+1];

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_rem[0] <= i_rem;
        r_lo[0]  <= i_lo;
        r_div[0] <= i_div;
        r_quo[0] <= '0;
    end

    // One trial subtraction per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        assign trial = {r_rem[k], r_lo[k][31]};
        assign diff  = trial - {1'b0, r_div[k]};
        assign ge    = (trial >= {1'b0, r_div[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k+1] <= r_tag[k];
            r_rem[k+1] <= ge ? diff[30:0] : trial[30:0];
            r_lo[k+1]  <= {r_lo[k][30:0], 1'b0};
            r_div[k+1] <= r_div[k];
            r_quo[k+1] <= {r_quo[k][STEPS-2:0], ge};
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_tag   = r_tag[STEPS];
    assign o_quo   = r_quo[STEPS];

endmodule

>>> hw/rtl/sgbt_back.sv
// ----------------------------------------------------------------------------
// sgbt_back
// Executes classified items: grid writes, bilinear interpolation over two
// row-parity banks, rounding to 1/256 m, and the radial taper with a
// pipelined divider.
// ----------------------------------------------------------------------------
module sgbt_back #(
    parameter int LON_POINTS = sgbt_pkg::LON_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sgbt_pkg::t_cmd i_cmd,
    input  sgbt_pkg::t_cfg i_cfg,
    output logic           o_done,
    output sgbt_pkg::t_res o_res
);

    localparam int LAT       = LON_POINTS / 2 + 1;
    localparam int COL_W     = $clog2(LON_POINTS);
    localparam int ROW_W     = $clog2(LAT);
    localparam int BANK_ROWS = (LAT + 1) / 2;
    localparam int BROW_W    = $clog2(BANK_ROWS);
    localparam int LON_W     = $clog2(LON_POINTS + 1);
    localparam int PW        = 32 + LON_W;

    // Scalars that travel with an item down to the divider.
    typedef struct packed {
        logic        is_query;
        logic        in_scope;
        logic        num_neg;
        logic [30:0] num_mag;
        logic        den_neg;
        logic [30:0] den_mag;
    } t_tail;

    typedef struct packed {
        t_tail              tail;
        logic [ROW_W-1:0]   row0;
        logic [ROW_W-1:0]   row1;
        logic [COL_W-1:0]   col0;
        logic [COL_W-1:0]   col1;
        logic [15:0]        wl1;
        logic [15:0]        wo1;
        logic signed [23:0] height;
    } t_s1;

    typedef struct packed {
        t_tail       tail;
        logic        p0;
        logic        p1;
        logic [16:0] wl0;
        logic [16:0] wl1;
        logic [16:0] wo0;
        logic [16:0] wo1;
    } t_s2;

    // ---------------- Stage 1: grid indexes, weights, taper terms ----------
    logic [PW-1:0]      plat;
    logic [PW-1:0]      plon;
    logic [LON_W-1:0]   lat_hi;
    logic [LON_W-1:0]   lon_hi;
    logic [ROW_W-1:0]   ilat0;
    logic [ROW_W-1:0]   ilat1;
    logic [COL_W-1:0]   ilon0;
    logic [COL_W-1:0]   ilon1;
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic [31:0]        num_abs;
    logic [31:0]        den_abs;
    t_s1                n_s1;
    t_s1                r_s1;
    logic               r_s1_v;

    always_comb begin
        plat   = PW'(i_cmd.theta) * PW'(LON_POINTS);
        plon   = PW'(i_cmd.phi) * PW'(LON_POINTS);
        lat_hi = plat[PW-1:32];
        lon_hi = plon[PW-1:32];
        ilat0  = (lat_hi > LON_W'(LAT - 1)) ? ROW_W'(LAT - 1) : ROW_W'(lat_hi);
        ilat1  = (ilat0 == ROW_W'(LAT - 1)) ? ilat0 : ilat0 + 1'b1;
        ilon0  = (lon_hi > LON_W'(LON_POINTS - 1)) ? COL_W'(LON_POINTS - 1)
                                                   : COL_W'(lon_hi);
        ilon1  = (ilon0 == COL_W'(LON_POINTS - 1)) ? '0 : ilon0 + 1'b1;

        // Taper toward the lower radius below the layer, else the upper.
        if (i_cmd.below) begin
            num = $signed({1'b0, i_cmd.point_radius}) - $signed({1'b0, i_cfg.lower});
            den = $signed({1'b0, i_cfg.layer}) - $signed({1'b0, i_cfg.lower});
        end else begin
            num = $signed({1'b0, i_cfg.upper}) - $signed({1'b0, i_cmd.point_radius});
            den = $signed({1'b0, i_cfg.upper}) - $signed({1'b0, i_cfg.layer});
        end
        num_abs = num[31] ? (32'd0 - num) : num;
        den_abs = den[31] ? (32'd0 - den) : den;

        n_s1.tail.is_query = i_cmd.is_query;
        n_s1.tail.in_scope = i_cmd.in_scope;
        n_s1.tail.num_neg  = num[31];
        n_s1.tail.num_mag  = num_abs[30:0];
        n_s1.tail.den_neg  = den[31];
        n_s1.tail.den_mag  = den_abs[30:0];
        n_s1.row0   = i_cmd.is_query ? ilat0 : ROW_W'(i_cmd.lat_row);
        n_s1.row1   = ilat1;
        n_s1.col0   = i_cmd.is_query ? ilon0 : COL_W'(i_cmd.lon_col);
        n_s1.col1   = ilon1;
        n_s1.wl1    = plat[31:16];
        n_s1.wo1    = plon[31:16];
        n_s1.height = i_cmd.height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // ---------------- Stage 2: grid banks by row parity ---------------------
    logic signed [23:0] r_rd0 [2];
    logic signed [23:0] r_rd1 [2];
    t_s2                r_s2;
    logic               r_s2_v;

    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic [23:0]      r_mem [BANK_ROWS][LON_POINTS];
        logic [ROW_W-1:0] rsel;
        logic [ROW_W-1:0] row_half;
        logic [ROW_W-1:0] wrow_half;

        // Each bank serves whichever of the two rows has its parity.
        assign rsel      = (r_s1.row0[0] == 1'(b)) ? r_s1.row0 : r_s1.row1;
        assign row_half  = rsel >> 1;
        assign wrow_half = r_s1.row0 >> 1;

        always_ff @(posedge i_clk) begin
            if (r_s1_v && !r_s1.tail.is_query && (r_s1.row0[0] == 1'(b))) begin
                r_mem[BROW_W'(wrow_half)][r_s1.col0] <= r_s1.height;
            end
            r_rd0[b] <= r_mem[BROW_W'(row_half)][r_s1.col0];
            r_rd1[b] <= r_mem[BROW_W'(row_half)][r_s1.col1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2.tail <= r_s1.tail;
        r_s2.p0   <= r_s1.row0[0];
        r_s2.p1   <= r_s1.row1[0];
        r_s2.wl1  <= {1'b0, r_s1.wl1};
        r_s2.wl0  <= 17'd65536 - {1'b0, r_s1.wl1};
        r_s2.wo1  <= {1'b0, r_s1.wo1};
        r_s2.wo0  <= 17'd65536 - {1'b0, r_s1.wo1};
    end

    // ---------------- Stage 3: corner times longitude weight ----------------
    logic signed [23:0] c00;
    logic signed [23:0] c01;
    logic signed [23:0] c10;
    logic signed [23:0] c11;
    logic signed [41:0] r_m00;
    logic signed [41:0] r_m01;
    logic signed [41:0] r_m10;
    logic signed [41:0] r_m11;
    logic [16:0]        r_s3_wl0;
    logic [16:0]        r_s3_wl1;
    t_tail              r_s3_tail;
    logic               r_s3_v;

    assign c00 = r_rd0[r_s2.p0];
    assign c01 = r_rd1[r_s2.p0];
    assign c10 = r_rd0[r_s2.p1];
    assign c11 = r_rd1[r_s2.p1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m00     <= c00 * $signed({1'b0, r_s2.wo0});
        r_m01     <= c01 * $signed({1'b0, r_s2.wo1});
        r_m10     <= c10 * $signed({1'b0, r_s2.wo0});
        r_m11     <= c11 * $signed({1'b0, r_s2.wo1});
        r_s3_wl0  <= r_s2.wl0;
        r_s3_wl1  <= r_s2.wl1;
        r_s3_tail <= r_s2.tail;
    end

    // ---------------- Stage 4: blend along longitude ------------------------
    logic signed [42:0] r_v0;
    logic signed [42:0] r_v1;
    logic [16:0]        r_s4_wl0;
    logic [16:0]        r_s4_wl1;
    t_tail              r_s4_tail;
    logic               r_s4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0      <= 43'(r_m00) + 43'(r_m01);
        r_v1      <= 43'(r_m10) + 43'(r_m11);
        r_s4_wl0  <= r_s3_wl0;
        r_s4_wl1  <= r_s3_wl1;
        r_s4_tail <= r_s3_tail;
    end

    // ---------------- Stage 5: times latitude weight ------------------------
    logic signed [60:0] r_p0;
    logic signed [60:0] r_p1;
    t_tail              r_s5_tail;
    logic               r_s5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0      <= r_v0 * $signed({1'b0, r_s4_wl0});
        r_p1      <= r_v1 * $signed({1'b0, r_s4_wl1});
        r_s5_tail <= r_s4_tail;
    end

    // ---------------- Stage 6: sum and round half up to 1/256 m -------------
    logic signed [61:0] acc_r;
    logic signed [32:0] dr8;
    logic [32:0]        dr_abs;
    logic [31:0]        r_dr_mag;
    logic               r_dr_neg;
    t_tail              r_s6_tail;
    logic               r_s6_v;

    assign acc_r  = 62'(r_p0) + 62'(r_p1) + 62'sd8388608;
    assign dr8    = acc_r[56:24];
    assign dr_abs = dr8[32] ? (33'd0 - dr8) : dr8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dr_mag  <= dr_abs[31:0];
        r_dr_neg  <= dr8[32];
        r_s6_tail <= r_s5_tail;
    end

    // ---------------- Stage 7: height times taper numerator -----------------
    logic [62:0] r_mag;
    logic        r_s7_neg;
    t_tail       r_s7_tail;
    logic        r_s7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else begin
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= 63'(r_dr_mag) * 63'(r_s6_tail.num_mag);
        r_s7_neg  <= r_dr_neg ^ r_s6_tail.num_neg ^ r_s6_tail.den_neg;
        r_s7_tail <= r_s6_tail;
    end

    // ---------------- Stage 8: round-to-nearest bias and overflow check -----
    // (mag + 128*den) / (256*den) equals ((mag + 128*den) >> 8) / den.
    logic [63:0]    biased;
    logic [55:0]    scaled;
    logic [30:0]    r_s8_rem;
    logic [31:0]    r_s8_lo;
    logic [30:0]    r_s8_div;
    sgbt_pkg::t_tag r_s8_tag;
    logic           r_s8_v;

    assign biased = {1'b0, r_mag} + {26'd0, r_s7_tail.den_mag, 7'd0};
    assign scaled = biased[63:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
        end else begin
            r_s8_v <= r_s7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s8_rem          <= 31'(scaled[55:32]);
        r_s8_lo           <= scaled[31:0];
        r_s8_div          <= r_s7_tail.den_mag;
        r_s8_tag.is_query <= r_s7_tail.is_query;
        r_s8_tag.in_scope <= r_s7_tail.in_scope;
        r_s8_tag.den_zero <= (r_s7_tail.den_mag == 31'd0);
        r_s8_tag.neg      <= r_s7_neg;
        r_s8_tag.ovf      <= (31'(scaled[55:32]) >= r_s7_tail.den_mag);
    end

    // ---------------- Divider ----------------------------------------------
    logic                       div_v;
    sgbt_pkg::t_tag             div_tag;
    logic [sgbt_pkg::QUO_W-1:0] div_quo;

    sgbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s8_v),
        .i_tag   (r_s8_tag),
        .i_rem   (r_s8_rem),
        .i_lo    (r_s8_lo),
        .i_div   (r_s8_div),
        .o_valid (div_v),
        .o_tag   (div_tag),
        .o_quo   (div_quo)
    );

    // ---------------- Output: sign, saturation and special cases ------------
    sgbt_pkg::t_res n_res;
    sgbt_pkg::t_res r_res;
    logic           r_done;

    always_comb begin
        n_res.in_scope = div_tag.in_scope;
        if (!div_tag.in_scope || div_tag.den_zero) begin
            n_res.delta_radius = 32'sd0;
        end else if (div_tag.neg) begin
            if (div_tag.ovf || (div_quo > 32'h8000_0000)) begin
                n_res.delta_radius = 32'sh8000_0000;
            end else begin
                n_res.delta_radius = 32'd0 - div_quo;
            end
        end else begin
            if (div_tag.ovf || (div_quo > 32'h7FFF_FFFF)) begin
                n_res.delta_radius = 32'sh7FFF_FFFF;
            end else begin
                n_res.delta_radius = div_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_v && div_tag.is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> hw/rtl/spherical_grid_bilinear_taper_core.sv
// ----------------------------------------------------------------------------
// spherical_grid_bilinear_taper_core
// Bilinear boundary-height lookup on a latitude by longitude grid with a
// linear radial taper.
//
// Usage: an item is taken on i_req at a clock edge where start is high and
// busy is low. A write item (req_type 0) stores one grid height and gives
// no result; writes outside the grid are dropped. A query item (req_type 1)
// gives exactly one result on o_res, shown for a single cycle with o_done
// high; the receiver takes it on that cycle and cannot hold it off.
// One item enters per cycle while busy is low: the grid sits in two
// row-parity banks with two read ports each, so all four corners are read
// together, and every stage is pipelined. busy rises only if the two-entry
// queue between front and back end fills. The three radius registers sit
// on the APB port at byte addresses 0, 4, 8, and are to be written only
// while the block is idle; the block itself does not enforce this.
// Synchronous reset clears the pipeline and the registers; grid contents
// stay undefined until written.
// ----------------------------------------------------------------------------
module spherical_grid_bilinear_taper_core #(
    parameter int LON_POINTS = sgbt_pkg::LON_POINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sgbt_pkg::t_req              i_req,
    output logic                        o_done,
    output sgbt_pkg::t_res              o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sgbt_pkg::ADDR_W-1:0] paddr,
    input  logic [sgbt_pkg::DATA_W-1:0] pwdata,
    output logic [sgbt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    sgbt_pkg::t_cfg r_cfg;
    logic           cfg_we;
    logic           q_full;
    logic           q_push;
    logic           q_valid;
    sgbt_pkg::t_cmd front_cmd;
    sgbt_pkg::t_cmd head_cmd;

    // Configuration port: a transfer completes in the access cycle.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_we) begin
            case (paddr[3:2])
                sgbt_pkg::REG_LAYER: begin
                    r_cfg.layer <= pwdata[sgbt_pkg::RAD_W-1:0];
                end
                sgbt_pkg::REG_LOWER: begin
                    r_cfg.lower <= pwdata[sgbt_pkg::RAD_W-1:0];
                end
                sgbt_pkg::REG_UPPER: begin
                    r_cfg.upper <= pwdata[sgbt_pkg::RAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            sgbt_pkg::REG_LAYER: prdata = {1'b0, r_cfg.layer};
            sgbt_pkg::REG_LOWER: prdata = {1'b0, r_cfg.lower};
            sgbt_pkg::REG_UPPER: prdata = {1'b0, r_cfg.upper};
            default:             prdata = '0;
        endcase
    end

    // Front end: accept and classify.
    sgbt_front #(
        .LON_POINTS (LON_POINTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_busy   (busy),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    // Queue between the two ends.
    sgbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Back end: grid access, interpolation and taper.
    sgbt_back #(
        .LON_POINTS (LON_POINTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .i_cfg   (r_cfg),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule
